/* sv/ssim_pkg.sv */
package ssim_pkg;

    localparam int FRAC_BITS = 22;
    localparam int IN_W      = 25;
    localparam int NORM_W    = 24;
    localparam int CNT_W     = 27;
    localparam int TERM_W    = 52;
    localparam int MAG_W     = TERM_W - 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int Q_W       = 26;
    localparam int DIVR_W    = 128;
    localparam int SUM_W     = 64;
    localparam int RAD_W     = 8 * NORM_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int ITER_W    = 7;
    localparam int TDATA_W   = 128;

    localparam logic [SUM_W-1:0] C1_U =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
    localparam logic [SUM_W-1:0] C2_U =
        ((64'd4 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MU, ST_TERM, ST_SMINIT, ST_SMUL, ST_QINIT, ST_QDIV, ST_DFIN,
        ST_POW0, ST_POW, ST_NLOAD, ST_NDIV, ST_NSTORE, ST_RLOAD, ST_RRUN,
        ST_RSTORE, ST_OUT
    } state_t;

    typedef enum logic [1:0] {RS_M2, RS_M4, RS_M8, RS_PREV} rsrc_t;
    typedef enum logic [1:0] {NS_NONE, NS_TWO, NS_FOUR, NS_EIGHT} nsel_t;

    typedef struct packed {
        logic       take_in;
        logic       mu;
        logic       term;
        logic       smul_init;
        logic       smul_step;
        logic       q_init;
        logic       q_step;
        logic       d_fin;
        logic       pow_first;
        logic       pow_step;
        logic       ndiv_load;
        logic       ndiv_step;
        logic       ndiv_store;
        logic [1:0] sum_idx;
        logic       root_load;
        logic       root_step;
        logic       root_store;
        rsrc_t      root_src;
        nsel_t      norm_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic ds_pos;
        logic iter_done;
        logic last;
        logic out_busy;
    } sts_t;

endpackage

/* sv/ssim_ctrl.sv */
module ssim_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ssim_pkg::sts_t  sts,
    output ssim_pkg::cmd_t  cmd
);

    ssim_pkg::state_t state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ssim_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ssim_pkg::ST_MU;
                end
            end
            ssim_pkg::ST_MU:     state_next = ssim_pkg::ST_TERM;
            ssim_pkg::ST_TERM:   state_next = ssim_pkg::ST_SMINIT;
            ssim_pkg::ST_SMINIT:
            begin
                state_next = sts.ds_pos ? ssim_pkg::ST_SMUL : ssim_pkg::ST_DFIN;
            end
            ssim_pkg::ST_SMUL:
            begin
                if (sts.iter_done)
                begin
                    state_next = ssim_pkg::ST_QINIT;
                end
            end
            ssim_pkg::ST_QINIT:  state_next = ssim_pkg::ST_QDIV;
            ssim_pkg::ST_QDIV:
            begin
                if (sts.iter_done)
                begin
                    state_next = ssim_pkg::ST_DFIN;
                end
            end
            ssim_pkg::ST_DFIN:   state_next = ssim_pkg::ST_POW0;
            ssim_pkg::ST_POW0:
            begin
                state_next = ssim_pkg::ST_POW;
                idx_next   = 3'd1;
            end
            ssim_pkg::ST_POW:
            begin
                if (idx_reg == 3'd3)
                begin
                    idx_next   = 3'd0;
                    state_next = sts.last ? ssim_pkg::ST_NLOAD : ssim_pkg::ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            ssim_pkg::ST_NLOAD:  state_next = ssim_pkg::ST_NDIV;
            ssim_pkg::ST_NDIV:
            begin
                if (sts.iter_done)
                begin
                    state_next = ssim_pkg::ST_NSTORE;
                end
            end
            ssim_pkg::ST_NSTORE:
            begin
                if (idx_reg == 3'd3)
                begin
                    idx_next   = 3'd0;
                    state_next = ssim_pkg::ST_RLOAD;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ssim_pkg::ST_NLOAD;
                end
            end
            ssim_pkg::ST_RLOAD:  state_next = ssim_pkg::ST_RRUN;
            ssim_pkg::ST_RRUN:
            begin
                if (sts.iter_done)
                begin
                    state_next = ssim_pkg::ST_RSTORE;
                end
            end
            ssim_pkg::ST_RSTORE:
            begin
                if (idx_reg == 3'd5)
                begin
                    idx_next   = 3'd0;
                    state_next = ssim_pkg::ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ssim_pkg::ST_RLOAD;
                end
            end
            ssim_pkg::ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ssim_pkg::ST_IDLE;
                end
            end
            default:             state_next = ssim_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.root_src = ssim_pkg::RS_M2;
        cmd.norm_sel = ssim_pkg::NS_NONE;
        cmd.sum_idx  = idx_reg[1:0];
        in_ready     = 1'b0;
        // root passes: m2 | m4, prev | m8, prev, prev
        case (idx_reg)
            3'd0:
            begin
                cmd.root_src = ssim_pkg::RS_M2;
                cmd.norm_sel = ssim_pkg::NS_TWO;
            end
            3'd1:    cmd.root_src = ssim_pkg::RS_M4;
            3'd2:
            begin
                cmd.root_src = ssim_pkg::RS_PREV;
                cmd.norm_sel = ssim_pkg::NS_FOUR;
            end
            3'd3:    cmd.root_src = ssim_pkg::RS_M8;
            3'd4:    cmd.root_src = ssim_pkg::RS_PREV;
            3'd5:
            begin
                cmd.root_src = ssim_pkg::RS_PREV;
                cmd.norm_sel = ssim_pkg::NS_EIGHT;
            end
            default: cmd.root_src = ssim_pkg::RS_PREV;
        endcase
        case (state_reg)
            ssim_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
            end
            ssim_pkg::ST_MU:     cmd.mu         = 1'b1;
            ssim_pkg::ST_TERM:   cmd.term       = 1'b1;
            ssim_pkg::ST_SMINIT: cmd.smul_init  = 1'b1;
            ssim_pkg::ST_SMUL:   cmd.smul_step  = 1'b1;
            ssim_pkg::ST_QINIT:  cmd.q_init     = 1'b1;
            ssim_pkg::ST_QDIV:   cmd.q_step     = 1'b1;
            ssim_pkg::ST_DFIN:   cmd.d_fin      = 1'b1;
            ssim_pkg::ST_POW0:   cmd.pow_first  = 1'b1;
            ssim_pkg::ST_POW:    cmd.pow_step   = 1'b1;
            ssim_pkg::ST_NLOAD:  cmd.ndiv_load  = 1'b1;
            ssim_pkg::ST_NDIV:   cmd.ndiv_step  = 1'b1;
            ssim_pkg::ST_NSTORE: cmd.ndiv_store = 1'b1;
            ssim_pkg::ST_RLOAD:  cmd.root_load  = 1'b1;
            ssim_pkg::ST_RRUN:   cmd.root_step  = 1'b1;
            ssim_pkg::ST_RSTORE: cmd.root_store = 1'b1;
            ssim_pkg::ST_OUT:    cmd.out_load   = !sts.out_busy;
            default:             cmd.take_in    = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssim_pkg::ST_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* sv/ssim_dp.sv */
module ssim_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssim_pkg::cmd_t                 cmd,
    output ssim_pkg::sts_t                 sts,
    input  logic [ssim_pkg::TDATA_W-1:0]   in_data,
    input  logic                           in_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssim_pkg::CNT_W-1:0]     cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ssim_pkg::TDATA_W-1:0]   out_data,
    output logic                           out_user
);

    localparam int F   = ssim_pkg::FRAC_BITS;
    localparam int IW  = ssim_pkg::IN_W;
    localparam int TW  = ssim_pkg::TERM_W;
    localparam int NW  = ssim_pkg::NORM_W;
    localparam int SW  = ssim_pkg::SUM_W;
    localparam int CW  = ssim_pkg::CNT_W;
    localparam int PW  = ssim_pkg::PROD_W;
    localparam int MW  = ssim_pkg::MAG_W;
    localparam int QW  = ssim_pkg::Q_W;
    localparam int DW  = ssim_pkg::DIVR_W;
    localparam int RW  = ssim_pkg::RAD_W;
    localparam int OW  = ssim_pkg::ROOT_W;
    localparam int EW  = ssim_pkg::REM_W;
    localparam int XW  = 32;
    localparam logic signed [TW-1:0] C1_T = TW'(ssim_pkg::C1_U);
    localparam logic signed [TW-1:0] C2_T = TW'(ssim_pkg::C2_U);
    localparam logic signed [29:0] ONE_W   = 30'sd1 <<< F;
    localparam logic signed [29:0] OMAX_W  = (30'sd1 <<< (IW - 1)) - 30'sd1;
    localparam logic signed [29:0] OMIN_W  = -(30'sd1 <<< (IW - 1));
    localparam logic [NW-1:0]        NMAX   = '1;
    localparam logic [RW-1:0]        RCAP   = RW'(1) << (8 * NW);

    logic [CW-1:0]        pc_reg, pc_next;
    logic signed [IW-1:0] mu1_reg, mu2_reg, s11_reg, s22_reg, s12_reg;
    logic                 last_reg;
    logic signed [2*IW-1:0] mu11_reg, mu22_reg, mu12_reg;
    logic signed [TW-1:0] nm_reg, ns_reg, dm_reg, ds_reg;
    logic                 neg_reg, neg_next;
    logic [PW-1:0]        a_reg, a_next, c_reg, c_next, accn_reg, accn_next;
    logic [PW-1:0]        accd_reg, accd_next;
    logic [MW-1:0]        b_reg, b_next, e_reg, e_next;
    logic                 sat_reg, sat_next;
    logic [DW-1:0]        r_reg, r_next, dd_reg, dd_next;
    logic [QW-1:0]        q_reg, q_next;
    logic signed [IW-1:0] dis_reg, dis_next;
    logic [XW-1:0]        x_reg, x_next;
    logic [SW-1:0]        sum_reg [4];
    logic [SW-1:0]        sum_next [4];
    logic [SW-1:0]        ndvd_reg, ndvd_next;
    logic [CW-1:0]        nrem_reg, nrem_next;
    logic [SW-1:0]        mean_reg [3];
    logic [SW-1:0]        mean_next [3];
    logic [RW-1:0]        rad_reg, rad_next;
    logic [OW-1:0]        root_reg, root_next, prev_reg, prev_next;
    logic [EW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        norm_reg [4];
    logic [NW-1:0]        norm_next [4];
    logic [ssim_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic                 ov_reg, ov_next;
    logic [ssim_pkg::TDATA_W-1:0] od_reg, od_next;
    logic                 ou_reg, ou_next;

    logic signed [TW-1:0]   s12_sc, s11_sc, s22_sc, nm_abs, ns_abs;
    logic signed [TW-1:0]   nm_c, ns_c, dm_c, ds_c;
    logic [QW:0]            sq;
    logic signed [29:0]     sq_w, dw;
    logic [2*XW-1:0]        prod;
    logic [SW-1:0]          pw;
    logic [SW:0]            su;
    logic signed [SW:0]     s0;
    logic [CW-1:0]          cnt_eff;
    logic [CW:0]            nt;
    logic [RW+7*F-1:0]      m8_big;
    logic [EW+1:0]          rt, trial;
    logic [1:0]             mi;

    always_comb
    begin
        s11_sc = {{(TW - IW - F){s11_reg[IW-1]}}, s11_reg, {F{1'b0}}};
        s22_sc = {{(TW - IW - F){s22_reg[IW-1]}}, s22_reg, {F{1'b0}}};
        s12_sc = {{(TW - IW - F){s12_reg[IW-1]}}, s12_reg, {F{1'b0}}};
        nm_c   = (TW'(mu12_reg) <<< 1) + C1_T;
        ns_c   = ((s12_sc - TW'(mu12_reg)) <<< 1) + C2_T;
        dm_c   = TW'(mu11_reg) + TW'(mu22_reg) + C1_T;
        ds_c   = (s11_sc - TW'(mu11_reg)) + (s22_sc - TW'(mu22_reg)) + C2_T;
        nm_abs = nm_reg[TW-1] ? -nm_reg : nm_reg;
        ns_abs = ns_reg[TW-1] ? -ns_reg : ns_reg;
        sq     = sat_reg ? (QW+1)'(1) << QW : {1'b0, q_reg};
        sq_w   = 30'(signed'({3'b000, sq}));
        if (neg_reg)
        begin
            sq_w = -sq_w;
        end
        dw      = ONE_W - sq_w;
        prod    = x_reg * x_reg;
        pw      = SW'(prod >> F);
        su      = {1'b0, sum_reg[cmd.sum_idx]} + {1'b0, pw};
        s0      = $signed({sum_reg[0][SW-1], sum_reg[0]}) + (SW+1)'(dis_reg);
        cnt_eff = (pc_reg == '0) ? CW'(1) : pc_reg;
        nt      = {nrem_reg, ndvd_reg[SW-1]};
        m8_big  = {mean_reg[2], {(7 * F){1'b0}}};
        rt      = {rem_reg, rad_reg[RW-1 -: 2]};
        trial   = (EW+2)'({root_reg, 2'b01});
        mi      = 2'(cmd.sum_idx - 2'd1);
    end

    always_comb
    begin
        pc_next   = pc_reg;
        neg_next  = neg_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        e_next    = e_reg;
        accn_next = accn_reg;
        accd_next = accd_reg;
        sat_next  = sat_reg;
        r_next    = r_reg;
        dd_next   = dd_reg;
        q_next    = q_reg;
        dis_next  = dis_reg;
        x_next    = x_reg;
        sum_next  = sum_reg;
        ndvd_next = ndvd_reg;
        nrem_next = nrem_reg;
        mean_next = mean_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        prev_next = prev_reg;
        rem_next  = rem_reg;
        norm_next = norm_reg;
        iter_next = iter_reg;
        ov_next   = ov_reg;
        od_next   = od_reg;
        ou_next   = ou_reg;

        if (cfg_valid)
        begin
            pc_next = cfg_data;
        end
        if (cmd.smul_step || cmd.q_step || cmd.ndiv_step || cmd.root_step)
        begin
            iter_next = (iter_reg == '0) ? iter_reg : iter_reg - 1'b1;
        end
        if (cmd.smul_init)
        begin
            neg_next  = nm_reg[TW-1] ^ ns_reg[TW-1];
            a_next    = PW'(nm_abs[MW-1:0]);
            b_next    = ns_abs[MW-1:0];
            c_next    = PW'(dm_reg[MW-1:0]);
            e_next    = ds_reg[MW-1:0];
            accn_next = '0;
            accd_next = '0;
            iter_next = ssim_pkg::ITER_W'(MW - 1);
        end
        if (cmd.smul_step)
        begin
            if (b_reg[0])
            begin
                accn_next = accn_reg + a_reg;
            end
            if (e_reg[0])
            begin
                accd_next = accd_reg + c_reg;
            end
            a_next = a_reg << 1;
            c_next = c_reg << 1;
            b_next = b_reg >> 1;
            e_next = e_reg >> 1;
        end
        if (cmd.q_init)
        begin
            sat_next  = {accn_reg, {F{1'b0}}} >= {accd_reg, {QW{1'b0}}};
            r_next    = DW'({accn_reg, {F{1'b0}}});
            dd_next   = DW'({accd_reg, {(QW - 1){1'b0}}});
            q_next    = '0;
            iter_next = ssim_pkg::ITER_W'(QW - 1);
        end
        if (cmd.q_step)
        begin
            if (r_reg >= dd_reg)
            begin
                r_next = r_reg - dd_reg;
                q_next = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QW-2:0], 1'b0};
            end
            dd_next = dd_reg >> 1;
        end
        if (cmd.d_fin)
        begin
            if (!sts.ds_pos || dw > OMAX_W)
            begin
                dis_next = IW'(OMAX_W);
            end
            else if (dw < OMIN_W)
            begin
                dis_next = IW'(OMIN_W);
            end
            else
            begin
                dis_next = dw[IW-1:0];
            end
        end
        if (cmd.pow_first)
        begin
            x_next = XW'(dis_reg[IW-1] ? -dis_reg : dis_reg);
            x_next = dis_reg[IW-1] ? XW'(-(XW'(dis_reg))) : XW'(dis_reg);
            if (s0[SW] != s0[SW-1])
            begin
                sum_next[0] = s0[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
            end
            else
            begin
                sum_next[0] = s0[SW-1:0];
            end
        end
        if (cmd.pow_step)
        begin
            x_next = pw[XW-1:0];
            sum_next[cmd.sum_idx] = su[SW] ? '1 : su[SW-1:0];
        end
        if (cmd.ndiv_load)
        begin
            if (cmd.sum_idx == 2'd0)
            begin
                ndvd_next = sum_reg[0][SW-1] ? '0 : sum_reg[0];
            end
            else
            begin
                ndvd_next = sum_reg[cmd.sum_idx];
            end
            nrem_next = '0;
            iter_next = ssim_pkg::ITER_W'(SW - 1);
        end
        if (cmd.ndiv_step)
        begin
            if (nt >= {1'b0, cnt_eff})
            begin
                nrem_next = CW'(nt - {1'b0, cnt_eff});
                ndvd_next = {ndvd_reg[SW-2:0], 1'b1};
            end
            else
            begin
                nrem_next = nt[CW-1:0];
                ndvd_next = {ndvd_reg[SW-2:0], 1'b0};
            end
        end
        if (cmd.ndiv_store)
        begin
            if (cmd.sum_idx == 2'd0)
            begin
                norm_next[0] = (ndvd_reg > SW'(NMAX)) ? NMAX : ndvd_reg[NW-1:0];
            end
            else
            begin
                mean_next[mi] = ndvd_reg;
            end
        end
        if (cmd.root_load)
        begin
            case (cmd.root_src)
                ssim_pkg::RS_M2: rad_next = RW'({mean_reg[0], {F{1'b0}}});
                ssim_pkg::RS_M4: rad_next = RW'({mean_reg[1], {(3 * F){1'b0}}});
                ssim_pkg::RS_M8: rad_next = (m8_big >= RCAP) ? RCAP : RW'(m8_big);
                default:         rad_next = RW'(prev_reg);
            endcase
            rem_next  = '0;
            root_next = '0;
            iter_next = ssim_pkg::ITER_W'(OW - 1);
        end
        if (cmd.root_step)
        begin
            if (rt >= trial)
            begin
                rem_next  = EW'(rt - trial);
                root_next = {root_reg[OW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rt[EW-1:0];
                root_next = {root_reg[OW-2:0], 1'b0};
            end
            rad_next = rad_reg << 2;
        end
        if (cmd.root_store)
        begin
            prev_next = root_reg;
            if (cmd.norm_sel != ssim_pkg::NS_NONE)
            begin
                norm_next[cmd.norm_sel] = (root_reg > OW'(NMAX)) ? NMAX : root_reg[NW-1:0];
            end
        end
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            ov_next = 1'b1;
            ou_next = last_reg;
            if (last_reg)
            begin
                od_next = ssim_pkg::TDATA_W'({norm_reg[3], norm_reg[2], norm_reg[1],
                                              norm_reg[0], dis_reg});
                for (int i = 0; i < 4; i++)
                begin
                    sum_next[i] = '0;
                end
            end
            else
            begin
                od_next = ssim_pkg::TDATA_W'(unsigned'(dis_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= CW'(1);
            ov_reg   <= 1'b0;
            iter_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            pc_reg   <= pc_next;
            ov_reg   <= ov_next;
            iter_reg <= iter_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            mu1_reg  <= in_data[0*IW +: IW];
            mu2_reg  <= in_data[1*IW +: IW];
            s11_reg  <= in_data[2*IW +: IW];
            s22_reg  <= in_data[3*IW +: IW];
            s12_reg  <= in_data[4*IW +: IW];
            last_reg <= in_last;
        end
        if (cmd.mu)
        begin
            mu11_reg <= mu1_reg * mu1_reg;
            mu22_reg <= mu2_reg * mu2_reg;
            mu12_reg <= mu1_reg * mu2_reg;
        end
        if (cmd.term)
        begin
            nm_reg <= nm_c;
            ns_reg <= ns_c;
            dm_reg <= dm_c;
            ds_reg <= ds_c;
        end
        neg_reg   <= neg_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        e_reg     <= e_next;
        accn_reg  <= accn_next;
        accd_reg  <= accd_next;
        sat_reg   <= sat_next;
        r_reg     <= r_next;
        dd_reg    <= dd_next;
        q_reg     <= q_next;
        dis_reg   <= dis_next;
        x_reg     <= x_next;
        ndvd_reg  <= ndvd_next;
        nrem_reg  <= nrem_next;
        mean_reg  <= mean_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        prev_reg  <= prev_next;
        rem_reg   <= rem_next;
        norm_reg  <= norm_next;
        od_reg    <= od_next;
        ou_reg    <= ou_next;
    end

    assign sts.ds_pos    = ds_reg > TW'(0);
    assign sts.iter_done = iter_reg == '0;
    assign sts.last      = last_reg;
    assign sts.out_busy  = ov_reg && !out_ready;
    assign cfg_ready     = 1'b1;
    assign out_valid     = ov_reg;
    assign out_data      = od_reg;
    assign out_user      = ou_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(ov_reg && !out_ready))
        else $error("result overwritten while pending");

    a_mul_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_init |-> (b_reg == '0 && e_reg == '0))
        else $error("serial multiply not finished");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_store |-> iter_reg == '0)
        else $error("root stored early");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && last_reg |=> (sum_reg[0] == '0 && sum_reg[3] == '0))
        else $error("sums not cleared after plane");

endmodule

/* sv/ssim_map_with_power_norms.sv */
// Each accepted pixel runs through the serial 51-step multiplier and the 26-step ratio
// divider before out_valid rises; both are skipped when the structure denominator is not
// positive. A plane's last pixel adds four 64-step divisions by pixel_count and six
// 97-step square-root passes. A new word is accepted only after the previous result is
// loaded for output, which waits while an earlier result is held by m_axis_tready.
// Reset: power sums cleared, pixel_count = 1, no result pending.
module ssim_map_with_power_norms (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // mean_ref, mean_dist, blur_sq_ref, blur_sq_dist, blur_cross, zero pad
    input  logic [ssim_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssim_pkg::CNT_W-1:0]    cfg_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // dissim, norm_one, norm_two, norm_four, norm_eight, zero pad
    output logic [ssim_pkg::TDATA_W-1:0]  m_axis_tdata,
    // norms_valid
    output logic                          m_axis_tuser
);

    ssim_pkg::cmd_t cmd;
    ssim_pkg::sts_t sts;

    ssim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssim_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

/* bench/tb_ssim_map_with_power_norms.sv */
module tb_ssim_map_with_power_norms;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIMIT   = 3000000;
    localparam longint OUT_MAX = 16777215;
    localparam longint OUT_MIN = -16777216;
    localparam longint ONE_Q   = 64'd1 << ssim_pkg::FRAC_BITS;
    localparam longint QI_SAT  = 1048576;

    typedef struct packed {
        logic signed [24:0] mean_ref;
        logic signed [24:0] mean_dist;
        logic signed [24:0] blur_sq_ref;
        logic signed [24:0] blur_sq_dist;
        logic signed [24:0] blur_cross;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic signed [24:0] dissim;
        logic [23:0]        norm_one;
        logic [23:0]        norm_two;
        logic [23:0]        norm_four;
        logic [23:0]        norm_eight;
        logic               norms_valid;
    } score_t;

    typedef struct {
        pixel_t px;
        bit     has_exp;
        longint exp_dissim;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ssim_pkg::TDATA_W-1:0]  s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ssim_pkg::CNT_W-1:0]    cfg_data = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ssim_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                          m_axis_tuser;

    score_t                        score_q[$];
    dir_row_t                      dir_rows[$];
    longint                        sum_d;
    logic [63:0]                   sum_pow[1:3];
    logic [ssim_pkg::CNT_W-1:0]    plane_pixels;
    int                            fails = 0;
    bit                            no_idle = 1'b0;
    longint                        cycles = 0;

    ssim_map_with_power_norms u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22);

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic logic [63:0] sq_q(logic [63:0] x);
        if (x >= 64'h1_0000_0000)
            return '1;
        return (x * x) >> ssim_pkg::FRAC_BITS;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    // largest r < 2^24 with r^k <= m * 2^(F*(k-1))
    function automatic logic [23:0] kth_root(logic [63:0] m, int k);
        logic [319:0] tgt;
        logic [319:0] pw;
        logic [23:0]  r;
        logic [23:0]  c;
        tgt = 320'(m) << (ssim_pkg::FRAC_BITS * (k - 1));
        r = '0;
        for (int b = 23; b >= 0; b--)
        begin
            c = r | (24'd1 << b);
            pw = 320'd1;
            for (int i = 0; i < k; i++)
                pw = pw * 320'(c);
            if (pw <= tgt)
                r = c;
        end
        return r;
    endfunction

    function automatic longint pixel_dissim(pixel_t p);
        longint mu1, mu2, s11, s22, s12, mu11, mu22, mu12, nm, ns, dm, ds, sq, d;
        logic [127:0] num, den;
        logic [149:0] quo;
        longint unsigned qi;
        mu1 = longint'(p.mean_ref);
        mu2 = longint'(p.mean_dist);
        s11 = longint'(p.blur_sq_ref) * ONE_Q;
        s22 = longint'(p.blur_sq_dist) * ONE_Q;
        s12 = longint'(p.blur_cross) * ONE_Q;
        mu11 = mu1 * mu1;
        mu22 = mu2 * mu2;
        mu12 = mu1 * mu2;
        nm = 2 * mu12 + longint'(ssim_pkg::C1_U);
        ns = 2 * (s12 - mu12) + longint'(ssim_pkg::C2_U);
        dm = mu11 + mu22 + longint'(ssim_pkg::C1_U);
        ds = (s11 - mu11) + (s22 - mu22) + longint'(ssim_pkg::C2_U);
        if (ds <= 0)
            return OUT_MAX;
        num = {64'd0, magn(nm)} * {64'd0, magn(ns)};
        den = {64'd0, 64'(dm)} * {64'd0, 64'(ds)};
        quo = {num, 22'd0} / {22'd0, den};
        if (quo[149:22] > 128'(QI_SAT))
            qi = QI_SAT;
        else
            qi = quo[63:22];
        sq = longint'((qi << ssim_pkg::FRAC_BITS) | quo[21:0]);
        if ((nm < 0) != (ns < 0))
            sq = -sq;
        d = ONE_Q - sq;
        if (d > OUT_MAX)
            d = OUT_MAX;
        if (d < OUT_MIN)
            d = OUT_MIN;
        return d;
    endfunction

    function automatic score_t score_pixel(pixel_t p);
        score_t r;
        longint d, m1;
        logic [63:0] p2, p4, p8, cnt;
        d = pixel_dissim(p);
        if (d > 0 && sum_d > 64'sh7FFF_FFFF_FFFF_FFFF - d)
            sum_d = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (d < 0 && sum_d < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - d)
            sum_d = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else
            sum_d = sum_d + d;
        p2 = sq_q(magn(d));
        p4 = sq_q(p2);
        p8 = sq_q(p4);
        sum_pow[1] = add_sat(sum_pow[1], p2);
        sum_pow[2] = add_sat(sum_pow[2], p4);
        sum_pow[3] = add_sat(sum_pow[3], p8);
        r = '0;
        r.dissim = d[24:0];
        if (p.last)
        begin
            cnt = (plane_pixels == 0) ? 64'd1 : 64'(plane_pixels);
            m1 = sum_d / longint'(cnt);
            if (m1 < 0)
                m1 = 0;
            if (m1 > OUT_MAX)
                m1 = OUT_MAX;
            r.norm_one = m1[23:0];
            r.norm_two = kth_root(sum_pow[1] / cnt, 2);
            r.norm_four = kth_root(sum_pow[2] / cnt, 4);
            r.norm_eight = kth_root(sum_pow[3] / cnt, 8);
            r.norms_valid = 1'b1;
            sum_d = 0;
            sum_pow[1] = '0;
            sum_pow[2] = '0;
            sum_pow[3] = '0;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        score_t exp_s;
        score_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.dissim = m_axis_tdata[24:0];
            got.norm_one = m_axis_tdata[48:25];
            got.norm_two = m_axis_tdata[72:49];
            got.norm_four = m_axis_tdata[96:73];
            got.norm_eight = m_axis_tdata[120:97];
            got.norms_valid = m_axis_tuser;
            if (score_q.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, got);
                fails++;
            end
            else
            begin
                exp_s = score_q.pop_front();
                if (got.dissim !== exp_s.dissim)
                    $display("%0t: dissim exp %0d got %0d", $realtime,
                             exp_s.dissim, got.dissim);
                if (got.norm_one !== exp_s.norm_one)
                    $display("%0t: norm_one exp %0d got %0d", $realtime,
                             exp_s.norm_one, got.norm_one);
                if (got.norm_two !== exp_s.norm_two)
                    $display("%0t: norm_two exp %0d got %0d", $realtime,
                             exp_s.norm_two, got.norm_two);
                if (got.norm_four !== exp_s.norm_four)
                    $display("%0t: norm_four exp %0d got %0d", $realtime,
                             exp_s.norm_four, got.norm_four);
                if (got.norm_eight !== exp_s.norm_eight)
                    $display("%0t: norm_eight exp %0d got %0d", $realtime,
                             exp_s.norm_eight, got.norm_eight);
                if (got.norms_valid !== exp_s.norms_valid)
                    $display("%0t: norms_valid exp %0b got %0b", $realtime,
                             exp_s.norms_valid, got.norms_valid);
                if (got !== exp_s)
                    fails++;
            end
        end
    end

    task automatic add_row(pixel_t px, bit has_exp, longint exp_dissim);
        dir_row_t row;
        row.px = px;
        row.has_exp = has_exp;
        row.exp_dissim = exp_dissim;
        dir_rows = {dir_rows, row};
    endtask

    task automatic send_pixel(pixel_t p, bit has_exp, longint exp_dissim);
        score_t s;
        while (!no_idle && $urandom_range(0, 99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'd0, p.blur_cross, p.blur_sq_dist, p.blur_sq_ref,
                         p.mean_dist, p.mean_ref};
        s_axis_tlast <= p.last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        s = score_pixel(p);
        if (has_exp)
            s.dissim = exp_dissim[24:0];
        score_q = {score_q, s};
    endtask

    task automatic write_count(logic [ssim_pkg::CNT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        wait (score_q.size() == 0);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        plane_pixels = v;
    endtask

    function automatic logic signed [24:0] clip25(longint v);
        if (v > OUT_MAX)
            return OUT_MAX[24:0];
        if (v < OUT_MIN)
            return OUT_MIN[24:0];
        return v[24:0];
    endfunction

    function automatic pixel_t rand_pixel(bit last);
        pixel_t p;
        longint m1, m2;
        if ($urandom_range(0, 9) < 7)
        begin
            m1 = longint'($urandom_range(0, 8388608)) - 2097152;
            m2 = m1 + longint'($urandom_range(0, 400000)) - 200000;
            p.mean_ref = clip25(m1);
            p.mean_dist = clip25(m2);
            p.blur_sq_ref = clip25(((m1 * m1) >>> ssim_pkg::FRAC_BITS)
                                   + $urandom_range(0, 300000) - 2000);
            p.blur_sq_dist = clip25(((m2 * m2) >>> ssim_pkg::FRAC_BITS)
                                    + $urandom_range(0, 300000) - 2000);
            p.blur_cross = clip25(((m1 * m2) >>> ssim_pkg::FRAC_BITS)
                                  + longint'($urandom_range(0, 300000)) - 150000);
        end
        else
        begin
            p.mean_ref = 25'($urandom());
            p.mean_dist = 25'($urandom());
            p.blur_sq_ref = 25'($urandom());
            p.blur_sq_dist = 25'($urandom());
            p.blur_cross = 25'($urandom());
        end
        p.last = last;
        return p;
    endfunction

    task automatic send_planes(int n_items, int max_len, bit match_count);
        int left;
        int len;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(1, max_len);
            if (len > left)
                len = left;
            if (match_count)
                write_count(ssim_pkg::CNT_W'(len));
            for (int i = 0; i < len; i++)
            begin
                no_idle = (left < n_items / 3) && (left > n_items / 6);
                send_pixel(rand_pixel(i == len - 1), 1'b0, 0);
                left--;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        sum_d = 0;
        sum_pow[1] = '0;
        sum_pow[2] = '0;
        sum_pow[3] = '0;
        plane_pixels = 1;
        // all zero: ratio exactly one
        add_row('{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 1'b1}, 1'b1, 0);
        add_row('{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 1'b0}, 1'b1, 0);
        // structure denominator not positive
        add_row('{25'sd4194304, 25'sd4194304, 25'sd0, 25'sd0, 25'sd0, 1'b0},
                1'b1, OUT_MAX);
        add_row('{-25'sd16777216, -25'sd16777216, -25'sd16777216,
                  -25'sd16777216, -25'sd16777216, 1'b0}, 1'b1, OUT_MAX);
        // huge ratio, both signs
        add_row('{25'sd0, 25'sd0, -25'sd1677, 25'sd0, 25'sd16777215, 1'b0},
                1'b1, OUT_MIN);
        add_row('{25'sd0, 25'sd0, -25'sd1677, 25'sd0, -25'sd16777216, 1'b1},
                1'b1, OUT_MAX);
        add_row('{25'sd16777215, 25'sd16777215, 25'sd16777215,
                  25'sd16777215, 25'sd16777215, 1'b0}, 1'b0, 0);
        add_row('{25'sd16777215, -25'sd16777216, 25'sd16777215,
                  25'sd16777215, -25'sd16777216, 1'b0}, 1'b0, 0);
        add_row('{25'sd4194304, 25'sd4194304, 25'sd4194304,
                  25'sd4194304, 25'sd4194304, 1'b1}, 1'b0, 0);
        // negative mean over a plane
        add_row('{25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd16777215, 1'b0}, 1'b0, 0);
        add_row('{25'sd0, 25'sd0, 25'sd100, 25'sd100, 25'sd16777215, 1'b1},
                1'b0, 0);
        add_row('{25'sd2097152, 25'sd1048576, 25'sd2000000, 25'sd300000,
                  25'sd600000, 1'b1}, 1'b0, 0);
        add_row('{-25'sd1, 25'sd1, 25'sd1, 25'sd1, -25'sd1, 1'b1}, 1'b0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].px, dir_rows[i].has_exp, dir_rows[i].exp_dissim);
        write_count(27'd0);
        send_planes(40, 6, 1'b0);
        write_count('1);
        send_planes(40, 12, 1'b0);
        write_count(27'd67108864);
        send_planes(30, 8, 1'b0);
        write_count(27'd3);
        send_planes(150, 10, 1'b0);
        send_planes(600, 24, 1'b1);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        wait (score_q.size() == 0);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
